// ===== design/lrcf_pkg.sv =====
package lrcf_pkg;

	// ring geometry
	localparam int RING_PIXELS = 60;
	localparam int PIX_W = 6;
	localparam logic [PIX_W-1:0] LAST_PIXEL = PIX_W'(RING_PIXELS - 1);
	localparam int BIN_PIXELS = 8;

	// queue depth between the decode front and the pixel back end
	localparam int QUEUE_DEPTH_DEF = 2;

	// display modes
	localparam logic [1:0] MODE_POINT = 2'd0;
	localparam logic [1:0] MODE_LINE = 2'd1;
	localparam logic [1:0] MODE_BINARY = 2'd2;

	// configuration register indexes
	localparam int CFG_IDX_W = 4;
	localparam logic [CFG_IDX_W-1:0] REG_DISPLAY_MODE = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HOUR_COLOR = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MINUTE_COLOR = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SECOND_COLOR = 4'd3;

	// register reset values
	localparam logic [23:0] HOUR_COLOR_RST = 24'hFF0000;
	localparam logic [23:0] MINUTE_COLOR_RST = 24'h00FF00;
	localparam logic [23:0] SECOND_COLOR_RST = 24'h0000FF;

	// hours register bits
	localparam int HREG_12H_BIT = 6;
	localparam int HREG_PM_BIT = 5;
	localparam int HREG_TENS_BIT = 4;

	// reciprocal for x / 12, exact for every 7-bit x
	localparam int DIV12_MUL = 43;
	localparam int DIV12_SHIFT = 9;

	typedef struct packed {
		logic [1:0] mode;
		logic [23:0] hour_color;
		logic [23:0] minute_color;
		logic [23:0] second_color;
	} cfg_t;

	// one classified reading, as the back end consumes it
	typedef struct packed {
		logic [7:0] hour;
		logic [6:0] minute;
		logic [6:0] second;
	} item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	function automatic logic [6:0] bcd_to_bin(input logic [6:0] x);
		logic [6:0] tens;
		tens = {4'd0, x[6:4]};
		return 7'((tens << 3) + (tens << 1) + {3'd0, x[3:0]});
	endfunction

	function automatic logic [2:0] div12(input logic [6:0] x);
		logic [12:0] prod;
		prod = 13'({6'd0, x} * 13'(DIV12_MUL));
		return prod[DIV12_SHIFT +: 3];
	endfunction

	// does a hand at this value light this pixel
	function automatic logic hand_lights(input logic [1:0] mode, input logic [7:0] value,
		input logic [PIX_W-1:0] pix);
		logic lit;
		case (mode)
			MODE_POINT: lit = ({2'd0, pix} == value);
			MODE_LINE: lit = ({2'd0, pix} < value);
			MODE_BINARY: lit = (pix < PIX_W'(BIN_PIXELS)) && value[pix[2:0]];
			default: lit = 1'b0;
		endcase
		return lit;
	endfunction

endpackage

// ===== design/lrcf_front.sv =====
module lrcf_front (
	input logic start,
	output logic busy,
	input logic [6:0] seconds_bcd,
	input logic [6:0] minutes_bcd,
	input logic [6:0] hours_reg,
	input logic [1:0] mode,
	input lrcf_pkg::q_status_t q_status,
	output logic push,
	output lrcf_pkg::item_t push_item
);
	import lrcf_pkg::*;

	logic [6:0] minute;
	logic [4:0] h12;
	logic [4:0] h12_wrap;
	logic [5:0] h24;
	logic [5:0] hour_raw;
	logic [7:0] hour_pos;
	logic [7:0] hour_wrap;

	// accept whenever the queue has room
	assign busy = q_status.full;
	assign push = start && !q_status.full;

	assign minute = bcd_to_bin(minutes_bcd);

	// twelve-hour decode: ones plus ten, fold at twelve, then PM
	always_comb begin
		h12 = {1'b0, hours_reg[3:0]} + (hours_reg[HREG_TENS_BIT] ? 5'd10 : 5'd0);
		h12_wrap = (h12 >= 5'd12) ? h12 - 5'd12 : h12;
		if (hours_reg[HREG_PM_BIT]) begin
			h12_wrap = h12_wrap + 5'd12;
		end
	end

	// twenty-four-hour decode: bits 5:4 as tens
	assign h24 = 6'(bcd_to_bin({1'b0, hours_reg[5:0]}));

	always_comb begin
		if (hours_reg[HREG_12H_BIT]) begin
			hour_raw = (mode == MODE_BINARY) ? {1'b0, h12} : {1'b0, h12_wrap};
		end else begin
			hour_raw = h24;
		end
	end

	// place the hour hand at hour*5 + minute/12, wrapped once
	always_comb begin
		hour_pos = {hour_raw, 2'b00} + {2'd0, hour_raw} + {5'd0, div12(minute)};
		hour_wrap = (hour_pos >= 8'(RING_PIXELS)) ? hour_pos - 8'(RING_PIXELS) : hour_pos;
	end

	always_comb begin
		push_item.hour = (mode == MODE_BINARY) ? {2'd0, hour_raw} : hour_wrap;
		push_item.minute = minute;
		push_item.second = bcd_to_bin(seconds_bcd);
	end

endmodule

// ===== design/lrcf_queue.sv =====
module lrcf_queue #(
	parameter int DEPTH = lrcf_pkg::QUEUE_DEPTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	input lrcf_pkg::item_t push_item,
	input logic pop,
	output lrcf_pkg::item_t head,
	output lrcf_pkg::q_status_t status
);
	import lrcf_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	item_t entries_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign status.full = (count_q == CNT_W'(DEPTH));
	assign status.empty = (count_q == '0);
	assign head = entries_q[rd_ptr_q];

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	// store a beat at the write pointer
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_item;
		end
	end

	// advance pointers and track fill
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== design/lrcf_back.sv =====
module lrcf_back (
	input logic clk,
	input logic arst_n,
	input lrcf_pkg::cfg_t cfg,
	input lrcf_pkg::item_t head,
	input lrcf_pkg::q_status_t q_status,
	output logic pop,
	output logic strobe,
	output logic [5:0] pixel_index,
	output logic [7:0] red,
	output logic [7:0] green,
	output logic [7:0] blue,
	output logic frame_last
);
	import lrcf_pkg::*;

	item_t item_q;
	logic [PIX_W-1:0] pix_q;
	logic active_q;
	logic strobe_q;
	logic [5:0] pixel_index_q;
	logic [7:0] red_q;
	logic [7:0] green_q;
	logic [7:0] blue_q;
	logic frame_last_q;

	logic [23:0] hour_c;
	logic [23:0] minute_c;
	logic [23:0] second_c;
	logic [23:0] mix;

	// take the next reading when idle or on the last pixel of a frame
	assign pop = !q_status.empty && (!active_q || pix_q == LAST_PIXEL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			pix_q <= '0;
		end else if (pop) begin
			active_q <= 1'b1;
			pix_q <= '0;
		end else if (active_q) begin
			if (pix_q == LAST_PIXEL) begin
				active_q <= 1'b0;
			end else begin
				pix_q <= pix_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			item_q <= head;
		end
	end

	// drop unlit hands to black, then take the channel maxima
	always_comb begin
		hour_c = hand_lights(cfg.mode, item_q.hour, pix_q) ? cfg.hour_color : '0;
		minute_c = hand_lights(cfg.mode, {1'b0, item_q.minute}, pix_q) ? cfg.minute_color : '0;
		second_c = hand_lights(cfg.mode, {1'b0, item_q.second}, pix_q) ? cfg.second_color : '0;
		for (int ch = 0; ch < 3; ch++) begin
			mix[ch*8 +: 8] = hour_c[ch*8 +: 8];
			if (minute_c[ch*8 +: 8] > mix[ch*8 +: 8]) begin
				mix[ch*8 +: 8] = minute_c[ch*8 +: 8];
			end
			if (second_c[ch*8 +: 8] > mix[ch*8 +: 8]) begin
				mix[ch*8 +: 8] = second_c[ch*8 +: 8];
			end
		end
	end

	// register the result beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= active_q;
		end
	end

	always_ff @(posedge clk) begin
		pixel_index_q <= pix_q;
		red_q <= mix[23:16];
		green_q <= mix[15:8];
		blue_q <= mix[7:0];
		frame_last_q <= (pix_q == LAST_PIXEL);
	end

	assign strobe = strobe_q;
	assign pixel_index = pixel_index_q;
	assign red = red_q;
	assign green = green_q;
	assign blue = blue_q;
	assign frame_last = frame_last_q;

endmodule

// ===== design/led_ring_clock_face.sv =====
// LED ring clock face.
// Input: one clock reading (seconds_bcd, minutes_bcd, hours_reg) is taken at a
// rising edge with start high and busy low. Busy is high only while the
// reading queue is full.
// Output: each reading gives 60 result beats, pixel 0 to 59 in order, one per
// cycle, each shown for one cycle with strobe high; frame_last marks pixel 59.
// The receiver cannot stall, so beats are never held back.
// When the pixel engine is idle, an accepted reading passes through the queue
// and the back end's reading and pixel registers before pixel 0 appears from
// the output registers. The pixel counter in the back end emits one pixel per
// cycle; frames from queued readings follow each other with no gap.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; ready is
// always high. Index 0 display mode, 1 hour, 2 minute, 3 second color; other
// indexes are ignored. Write only while no frame is pending.
// Reset: registers return to point mode and red/green/blue hand colors, the
// queue empties and no beat is shown.
module led_ring_clock_face #(
	parameter int QUEUE_DEPTH = lrcf_pkg::QUEUE_DEPTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic [6:0] seconds_bcd,
	input logic [6:0] minutes_bcd,
	input logic [6:0] hours_reg,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [lrcf_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [23:0] cfg_data,
	output logic strobe,
	output logic [5:0] pixel_index,
	output logic [7:0] red,
	output logic [7:0] green,
	output logic [7:0] blue,
	output logic frame_last
);
	import lrcf_pkg::*;

	cfg_t cfg_q;
	logic push;
	logic pop;
	item_t push_item;
	item_t head;
	q_status_t q_status;

	assign cfg_ready = 1'b1;

	// hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode <= MODE_POINT;
			cfg_q.hour_color <= HOUR_COLOR_RST;
			cfg_q.minute_color <= MINUTE_COLOR_RST;
			cfg_q.second_color <= SECOND_COLOR_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_DISPLAY_MODE: cfg_q.mode <= cfg_data[1:0];
				REG_HOUR_COLOR: cfg_q.hour_color <= cfg_data;
				REG_MINUTE_COLOR: cfg_q.minute_color <= cfg_data;
				REG_SECOND_COLOR: cfg_q.second_color <= cfg_data;
				default: ;
			endcase
		end
	end

	lrcf_front u_front (
		.start(start),
		.busy(busy),
		.seconds_bcd(seconds_bcd),
		.minutes_bcd(minutes_bcd),
		.hours_reg(hours_reg),
		.mode(cfg_q.mode),
		.q_status(q_status),
		.push(push),
		.push_item(push_item)
	);

	lrcf_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_item(push_item),
		.pop(pop),
		.head(head),
		.status(q_status)
	);

	lrcf_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.head(head),
		.q_status(q_status),
		.pop(pop),
		.strobe(strobe),
		.pixel_index(pixel_index),
		.red(red),
		.green(green),
		.blue(blue),
		.frame_last(frame_last)
	);

endmodule

// ===== design/lrcf_checker.sv =====
module lrcf_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic strobe,
	input logic [5:0] pixel_index,
	input logic frame_last
);
	import lrcf_pkg::*;

	// a frame runs on without gaps, one pixel a cycle
	a_frame_step: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && pixel_index != LAST_PIXEL |=>
		strobe && pixel_index == $past(pixel_index) + 6'd1)
		else $error("frame broke off or skipped a pixel");

	// a frame only starts at pixel zero
	a_frame_entry: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && pixel_index != 6'd0 |-> $past(strobe))
		else $error("frame began past pixel zero");

	// the last flag sits on pixel 59 alone
	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> frame_last == (pixel_index == LAST_PIXEL))
		else $error("frame_last misplaced");

	// the queue only fills after an accepted reading
	a_busy_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy rose without a start");

endmodule

bind led_ring_clock_face lrcf_checker u_lrcf_checker (.*);

// ===== tb/led_ring_clock_face_test.sv =====
`timescale 1ns / 100ps

module led_ring_clock_face_test;
	import lrcf_pkg::*;

	// fourth mode value, renders black
	localparam logic [1:0] MODE_DARK = 2'd3;
	localparam logic [6:0] NO_SPOT = 7'h7F;
	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE_CYCLES = 8;
	localparam int PHASES = 9;
	localparam int PHASE_READINGS = 40;
	localparam int DIR_COUNT = 24;

	logic clk;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [6:0] seconds_bcd = '0;
	logic [6:0] minutes_bcd = '0;
	logic [6:0] hours_reg = '0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [23:0] cfg_data = '0;
	logic strobe;
	logic [5:0] pixel_index;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic frame_last;

	// one pixel of a rendered frame
	typedef struct packed {
		logic [5:0] pix;
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		logic last;
	} ring_beat_t;

	// directed reading; typed rows give the whole frame as fill plus one spot
	typedef struct packed {
		logic [1:0] mode;
		logic [6:0] sec;
		logic [6:0] min;
		logic [6:0] hrs;
		logic typed;
		logic [23:0] fill;
		logic [6:0] spot;
		logic [23:0] spot_rgb;
	} face_row_t;

	localparam face_row_t DIR_ROWS [DIR_COUNT] = '{
		'{MODE_POINT, 7'h00, 7'h00, 7'h00, 1'b1, 24'h000000, 7'd0, 24'hFFFFFF},
		'{MODE_POINT, 7'h59, 7'h59, 7'h23, 1'b0, 24'h0, NO_SPOT, 24'h0},
		'{MODE_POINT, 7'h30, 7'h30, 7'h12, 1'b0, 24'h0, NO_SPOT, 24'h0},
		'{MODE_POINT, 7'h7F, 7'h7F, 7'h3F, 1'b1, 24'h000000, NO_SPOT, 24'h0},
		'{MODE_POINT, 7'h7F, 7'h7F, 7'h7F, 1'b0, 24'h0, NO_SPOT, 24'h0},
		'{MODE_POINT, 7'h00, 7'h00, 7'h40, 1'b0, 24'h0, NO_SPOT, 24'h0},
		'{MODE_POINT, 7'h00, 7'h00, 7'h52, 1'b0, 24'h0, NO_SPOT, 24'h0},
		'{MODE_POINT, 7'h15, 7'h45, 7'h72, 1'b0, 24'h0, NO_SPOT, 24'h0},
		'{MODE_POINT, 7'h00, 7'h59, 7'h71, 1'b0, 24'h0, NO_SPOT, 24'h0},
		'{MODE_POINT, 7'h0F, 7'h0A, 7'h1F, 1'b0, 24'h0, NO_SPOT, 24'h0},
		'{MODE_POINT, 7'h45, 7'h15, 7'h19, 1'b0, 24'h0, NO_SPOT, 24'h0},
		'{MODE_LINE, 7'h00, 7'h00, 7'h00, 1'b1, 24'h000000, NO_SPOT, 24'h0},
		'{MODE_LINE, 7'h59, 7'h59, 7'h23, 1'b0, 24'h0, NO_SPOT, 24'h0},
		'{MODE_LINE, 7'h7F, 7'h7F, 7'h3F, 1'b1, 24'hFFFFFF, NO_SPOT, 24'h0},
		'{MODE_LINE, 7'h30, 7'h12, 7'h65, 1'b0, 24'h0, NO_SPOT, 24'h0},
		'{MODE_LINE, 7'h01, 7'h01, 7'h00, 1'b0, 24'h0, NO_SPOT, 24'h0},
		'{MODE_BINARY, 7'h7F, 7'h7F, 7'h7F, 1'b0, 24'h0, NO_SPOT, 24'h0},
		'{MODE_BINARY, 7'h55, 7'h2A, 7'h40, 1'b0, 24'h0, NO_SPOT, 24'h0},
		'{MODE_BINARY, 7'h00, 7'h00, 7'h00, 1'b1, 24'h000000, NO_SPOT, 24'h0},
		'{MODE_BINARY, 7'h2A, 7'h55, 7'h3F, 1'b0, 24'h0, NO_SPOT, 24'h0},
		'{MODE_BINARY, 7'h07, 7'h70, 7'h6F, 1'b0, 24'h0, NO_SPOT, 24'h0},
		'{MODE_DARK, 7'h59, 7'h59, 7'h23, 1'b1, 24'h000000, NO_SPOT, 24'h0},
		'{MODE_DARK, 7'h7F, 7'h7F, 7'h7F, 1'b1, 24'h000000, NO_SPOT, 24'h0},
		'{MODE_POINT, 7'h00, 7'h00, 7'h00, 1'b1, 24'h000000, 7'd0, 24'hFFFFFF}
	};

	// shadow copy of the registers
	logic [1:0] face_mode = MODE_POINT;
	logic [23:0] hour_rgb = HOUR_COLOR_RST;
	logic [23:0] minute_rgb = MINUTE_COLOR_RST;
	logic [23:0] second_rgb = SECOND_COLOR_RST;

	ring_beat_t pending_beats[$];
	int n_errors = 0;
	int n_beats = 0;
	int n_readings = 0;
	int n_writes = 0;

	led_ring_clock_face u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.seconds_bcd(seconds_bcd),
		.minutes_bcd(minutes_bcd),
		.hours_reg(hours_reg),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.strobe(strobe),
		.pixel_index(pixel_index),
		.red(red),
		.green(green),
		.blue(blue),
		.frame_last(frame_last)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// stop a hung run
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("timeout after %0d cycles, %0d beats outstanding", CYCLE_LIMIT,
			pending_beats.size());
		$display("status: fail");
		$finish;
	end

	function automatic logic [6:0] digits_value(input logic [6:0] d);
		return 7'(int'(d[6:4]) * 10 + int'(d[3:0]));
	endfunction

	function automatic logic [6:0] to_bcd(input int v);
		return {3'(v / 10), 4'(v % 10)};
	endfunction

	function automatic logic hand_on(input logic [1:0] mode, input logic [7:0] value,
		input int pix);
		case (mode)
			MODE_POINT: return value == 8'(pix);
			MODE_LINE: return 8'(pix) < value;
			MODE_BINARY: begin
				if (pix >= 8) return 1'b0;
				return value[pix];
			end
			default: return 1'b0;
		endcase
	endfunction

	function automatic logic [23:0] brighter(input logic [23:0] a, input logic [23:0] b);
		logic [23:0] m;
		for (int k = 0; k < 3; k++) m[k*8 +: 8] = (a[k*8 +: 8] > b[k*8 +: 8]) ?
			a[k*8 +: 8] : b[k*8 +: 8];
		return m;
	endfunction

	// queue the frame one reading renders under the current registers
	task automatic predict_face(input logic [6:0] s, input logic [6:0] m, input logic [6:0] h);
		logic [7:0] sec_v;
		logic [7:0] min_v;
		logic [7:0] hr;
		logic [23:0] rgb;
		sec_v = {1'b0, digits_value(s)};
		min_v = {1'b0, digits_value(m)};
		if (h[HREG_12H_BIT]) begin
			hr = 8'(h[3:0]) + (h[HREG_TENS_BIT] ? 8'd10 : 8'd0);
			if (face_mode != MODE_BINARY) begin
				if (hr >= 8'd12) hr = hr - 8'd12;
				if (h[HREG_PM_BIT]) hr = hr + 8'd12;
			end
		end else begin
			hr = {1'b0, digits_value(h)};
		end
		// place the hour hand, wrapped only once
		if (face_mode != MODE_BINARY) begin
			hr = 8'(int'(hr) * 5 + int'(min_v) / 12);
			if (hr >= 8'(RING_PIXELS)) hr = hr - 8'(RING_PIXELS);
		end
		for (int p = 0; p < RING_PIXELS; p++) begin
			rgb = '0;
			if (hand_on(face_mode, hr, p)) rgb = brighter(rgb, hour_rgb);
			if (hand_on(face_mode, min_v, p)) rgb = brighter(rgb, minute_rgb);
			if (hand_on(face_mode, sec_v, p)) rgb = brighter(rgb, second_rgb);
			pending_beats.push_back('{6'(p), rgb[23:16], rgb[15:8], rgb[7:0],
				6'(p) == LAST_PIXEL});
		end
	endtask

	// present one reading and hold it until the block takes it
	task automatic put_reading(input logic [6:0] s, input logic [6:0] m, input logic [6:0] h);
		start <= 1'b1;
		seconds_bcd <= s;
		minutes_bcd <= m;
		hours_reg <= h;
		do @(posedge clk); while (busy);
		n_readings++;
	endtask

	// leave cfg_valid high; the caller drops it after its last write
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [23:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_DISPLAY_MODE: face_mode = data[1:0];
			REG_HOUR_COLOR: hour_rgb = data;
			REG_MINUTE_COLOR: minute_rgb = data;
			REG_SECOND_COLOR: second_rgb = data;
			default: ;
		endcase
		n_writes++;
	endtask

	// drop start and wait for every queued frame to come out
	task automatic drain_frames();
		start <= 1'b0;
		while (pending_beats.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// mostly valid clock readings, some raw register noise
	task automatic pick_reading(output logic [6:0] s, output logic [6:0] m,
		output logic [6:0] h);
		int hv;
		if ($urandom_range(99) < 75) begin
			s = to_bcd($urandom_range(59));
			m = to_bcd($urandom_range(59));
			if ($urandom_range(1) == 0) begin
				h = to_bcd($urandom_range(23));
			end else begin
				hv = $urandom_range(1, 12);
				h = {1'b1, 1'($urandom_range(1)), hv >= 10, 4'(hv % 10)};
			end
		end else begin
			s = 7'($urandom);
			m = 7'($urandom);
			h = 7'($urandom);
		end
	endtask

	function automatic logic [23:0] pick_color(input int ph);
		case (ph)
			0: return 24'h000000;
			1: return 24'hFFFFFF;
			default: return 24'($urandom);
		endcase
	endfunction

	// compare each beat with the oldest expected pixel
	always @(posedge clk) begin : beat_check
		ring_beat_t want;
		if (strobe) begin
			if (pending_beats.size() == 0) begin
				$error("beat for pixel %0d with no frame expected", pixel_index);
				n_errors++;
			end else begin
				want = pending_beats.pop_front();
				n_beats++;
				if (pixel_index !== want.pix) begin
					$error("pixel_index expected %0d got %0d", want.pix, pixel_index);
					n_errors++;
				end
				if (red !== want.r) begin
					$error("red expected %0h got %0h", want.r, red);
					n_errors++;
				end
				if (green !== want.g) begin
					$error("green expected %0h got %0h", want.g, green);
					n_errors++;
				end
				if (blue !== want.b) begin
					$error("blue expected %0h got %0h", want.b, blue);
					n_errors++;
				end
				if (frame_last !== want.last) begin
					$error("frame_last expected %0b got %0b", want.last, frame_last);
					n_errors++;
				end
			end
		end
	end

	initial begin : stimulus
		face_row_t row;
		logic [6:0] s;
		logic [6:0] m;
		logic [6:0] h;
		logic [23:0] rgb;
		logic [1:0] mode_pick;
		bit quiet;
		int gap;

		// hold reset at the start, then release it
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows, starting from the reset registers
		for (int i = 0; i < DIR_COUNT; i++) begin
			row = DIR_ROWS[i];
			if (row.mode != face_mode) begin
				drain_frames();
				write_reg(REG_DISPLAY_MODE, {22'd0, row.mode});
				cfg_valid <= 1'b0;
			end
			put_reading(row.sec, row.min, row.hrs);
			if (row.typed) begin
				for (int p = 0; p < RING_PIXELS; p++) begin
					rgb = (7'(p) == row.spot) ? row.spot_rgb : row.fill;
					pending_beats.push_back('{6'(p), rgb[23:16], rgb[15:8], rgb[7:0],
						6'(p) == LAST_PIXEL});
				end
			end else begin
				predict_face(row.sec, row.min, row.hrs);
			end
		end

		// random phases, each under fresh register settings
		for (int ph = 0; ph < PHASES; ph++) begin
			drain_frames();
			// unused indexes must leave every register alone
			write_reg(CFG_IDX_W'($urandom_range(4, 15)), 24'($urandom));
			mode_pick = 2'(ph % 4);
			write_reg(REG_DISPLAY_MODE, {22'($urandom), mode_pick});
			write_reg(REG_HOUR_COLOR, pick_color(ph));
			write_reg(REG_MINUTE_COLOR, pick_color(ph));
			write_reg(REG_SECOND_COLOR, pick_color(ph));
			cfg_valid <= 1'b0;
			quiet = (ph == 4) || (ph == 5);
			for (int k = 0; k < PHASE_READINGS; k++) begin
				pick_reading(s, m, h);
				put_reading(s, m, h);
				predict_face(s, m, h);
				if (!quiet && $urandom_range(99) < 6) begin
					start <= 1'b0;
					gap = ($urandom_range(1) == 0) ? $urandom_range(1, 3) :
						$urandom_range(4, 120);
					repeat (gap) @(posedge clk);
				end
			end
		end

		drain_frames();
		$display("covered %0d readings in point, line, binary and dark modes", n_readings);
		$display("%0d pixel beats compared, %0d register writes", n_beats, n_writes);
		if (n_errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

// ===== led_ring_clock_face.f =====
design/lrcf_pkg.sv
design/lrcf_front.sv
design/lrcf_queue.sv
design/lrcf_back.sv
design/led_ring_clock_face.sv
design/lrcf_checker.sv
tb/led_ring_clock_face_test.sv
